FILE: sv/rrs_pkg.sv
package rrs_pkg;

  localparam int SlotCountDef  = 16;
  localparam int KernelSlotDef = 0;
  localparam int OpW           = 3;
  localparam int SlotW         = 4;
  localparam int StatusW       = 2;
  localparam int CountW        = 32;

  typedef enum logic [OpW-1:0] {
    OP_ADD       = 3'd0,
    OP_SET_RUN   = 3'd1,
    OP_SET_IDLE  = 3'd2,
    OP_SWITCH    = 3'd3,
    OP_RESET_CUR = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef struct packed {
    logic             valid;
    logic [OpW-1:0]   op;
    logic [SlotW-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [SlotW-1:0]   result_slot;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  switch_count;
  } res_t;

endpackage

FILE: sv/rrs_pick.sv
module rrs_pick #(
  parameter int SLOT_COUNT = rrs_pkg::SlotCountDef,
  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic [SLOT_COUNT-1:0] req_i,
  input  logic [SLOT_COUNT-1:0] above_i,
  output logic                  found_o,
  output logic [IdxW-1:0]       idx_o
);

  logic [SLOT_COUNT-1:0] hi;
  logic [SLOT_COUNT-1:0] pool;

  // lowest request above the start point, else lowest request overall
  always_comb begin
    hi      = req_i & above_i;
    pool    = (|hi) ? hi : req_i;
    found_o = |req_i;
    idx_o   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (pool[i]) begin
        idx_o = IdxW'(i);
      end
    end
  end

endmodule

FILE: sv/rrs_table.sv
module rrs_table #(
  parameter int SLOT_COUNT  = rrs_pkg::SlotCountDef,
  parameter int KERNEL_SLOT = rrs_pkg::KernelSlotDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rrs_pkg::cmd_t   cmd_i,
  output rrs_pkg::res_t   res_o
);

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_COUNT-1:0] ResetBits =
    {{(SLOT_COUNT-1){1'b0}}, 1'b1} << KERNEL_SLOT;

  logic [SLOT_COUNT-1:0]     present_q, present_d;
  logic [SLOT_COUNT-1:0]     runnable_q, runnable_d;
  logic [SLOT_COUNT-1:0]     marks_q, marks_d;
  logic [IdxW-1:0]           cur_q, cur_d;
  logic [rrs_pkg::CountW-1:0] count_q, count_d;

  logic [SLOT_COUNT-1:0] above;
  logic [SLOT_COUNT-1:0] tgt_hot;
  logic [SLOT_COUNT-1:0] cur_hot;
  logic [SLOT_COUNT-1:0] free_hot;
  logic                  tgt_in_range;
  logic [IdxW-1:0]       tgt_idx;
  logic                  free_found;
  logic [IdxW-1:0]       free_idx;
  logic                  run_found;
  logic [IdxW-1:0]       run_idx;

  assign tgt_idx      = IdxW'(cmd_i.slot);
  assign tgt_in_range = (int'(cmd_i.slot) < SLOT_COUNT);

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      above[i]    = (IdxW'(i) > cur_q);
      tgt_hot[i]  = tgt_in_range && (IdxW'(i) == tgt_idx);
      cur_hot[i]  = (IdxW'(i) == cur_q);
      free_hot[i] = (IdxW'(i) == free_idx);
    end
  end

  rrs_pick #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_free_pick (
    .req_i  (~present_q),
    .above_i('0),
    .found_o(free_found),
    .idx_o  (free_idx)
  );

  rrs_pick #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_run_pick (
    .req_i  (present_q & runnable_q),
    .above_i(above),
    .found_o(run_found),
    .idx_o  (run_idx)
  );

  always_comb begin
    present_d  = present_q;
    runnable_d = runnable_q;
    marks_d    = marks_q;
    cur_d      = cur_q;
    count_d    = count_q;
    res_o.result_slot = rrs_pkg::SlotW'(cur_q);
    res_o.status      = rrs_pkg::ST_OK;
    case (cmd_i.op)
      rrs_pkg::OP_ADD: begin
        if (free_found) begin
          present_d  = present_q | free_hot;
          runnable_d = runnable_q & ~free_hot;
          res_o.result_slot = rrs_pkg::SlotW'(free_idx);
        end else begin
          res_o.result_slot = '0;
          res_o.status      = rrs_pkg::ST_FULL;
        end
      end
      rrs_pkg::OP_SET_RUN: begin
        runnable_d = runnable_q | tgt_hot;
        res_o.result_slot = cmd_i.slot;
      end
      rrs_pkg::OP_SET_IDLE: begin
        runnable_d = runnable_q & ~tgt_hot;
        res_o.result_slot = cmd_i.slot;
      end
      rrs_pkg::OP_SWITCH: begin
        if (run_found) begin
          cur_d   = run_idx;
          count_d = count_q + 1'b1;
          res_o.result_slot = rrs_pkg::SlotW'(run_idx);
        end else begin
          res_o.status = rrs_pkg::ST_NONE;
        end
      end
      rrs_pkg::OP_RESET_CUR: begin
        runnable_d = runnable_q & ~cur_hot;
        marks_d    = marks_q | cur_hot;
      end
      default: begin
      end
    endcase
    res_o.switch_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= ResetBits;
      runnable_q <= ResetBits;
      marks_q    <= '0;
      cur_q      <= '0;
      count_q    <= '0;
    end else if (cmd_i.valid) begin
      present_q  <= present_d;
      runnable_q <= runnable_d;
      marks_q    <= marks_d;
      cur_q      <= cur_d;
      count_q    <= count_d;
    end
  end

endmodule

FILE: sv/round_robin_slot_scheduler.sv
// channel | dir | handshake              | payload
// in      | in  | in_valid_i / in_stall_o | operation_i, slot_i
// out     | out | out_valid_o / out_stall_i | result_slot_o, status_o, switch_count_o
//
// One operation per cycle sustained while out_stall_i does not hold the result; each
// beat passes the input register, then the table update and the result register.
// The rotated find-first over present and runnable bits is a single pass.
// Reset: only the kernel slot present and runnable, current slot and count zero.
// An output stall holds the result and backs up into in_stall_o.
module round_robin_slot_scheduler #(
  parameter int SLOT_COUNT  = rrs_pkg::SlotCountDef,
  parameter int KERNEL_SLOT = rrs_pkg::KernelSlotDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rrs_pkg::OpW-1:0]     operation_i,
  input  logic [rrs_pkg::SlotW-1:0]   slot_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rrs_pkg::SlotW-1:0]   result_slot_o,
  output logic [rrs_pkg::StatusW-1:0] status_o,
  output logic [rrs_pkg::CountW-1:0]  switch_count_o
);

  logic                      in_vld_q, in_vld_d;
  logic [rrs_pkg::OpW-1:0]   in_op_q;
  logic [rrs_pkg::SlotW-1:0] in_slot_q;
  logic                      out_vld_q, out_vld_d;
  rrs_pkg::res_t             out_res_q;
  rrs_pkg::res_t             res;
  rrs_pkg::cmd_t             cmd;
  logic                      out_ready;
  logic                      in_take;
  logic                      fire;

  assign out_ready  = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;
  assign fire       = in_vld_q && out_ready;

  assign cmd.valid = fire;
  assign cmd.op    = in_op_q;
  assign cmd.slot  = in_slot_q;

  rrs_table #(
    .SLOT_COUNT (SLOT_COUNT),
    .KERNEL_SLOT(KERNEL_SLOT)
  ) u_table (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .res_o (res)
  );

  assign in_vld_d  = in_take ? 1'b1 : (fire ? 1'b0 : in_vld_q);
  assign out_vld_d = out_ready ? fire : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      out_res_q <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (fire) begin
        out_res_q <= res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q   <= operation_i;
      in_slot_q <= slot_i;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign result_slot_o  = out_res_q.result_slot;
  assign status_o       = out_res_q.status;
  assign switch_count_o = out_res_q.switch_count;

  a_fire_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("processed beat did not reach the result register");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_op_q != rrs_pkg::OP_SWITCH)
      |=> out_res_q.switch_count == $past(out_res_q.switch_count))
    else $error("switch count moved on a non-switch beat");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_op_q == rrs_pkg::OP_SWITCH)
      |=> (out_res_q.switch_count == $past(out_res_q.switch_count) + 1'b1)
          || (out_res_q.status == rrs_pkg::ST_NONE))
    else $error("successful switch did not advance the count by one");

endmodule
